// ===== src/ptm_pkg.sv =====
// Package with the widths, byte codes and pipeline types of the text measure block.
`timescale 1ns / 1ps

package ptm_pkg;

  // Field widths
  localparam int CODE_W   = 8;
  localparam int PIX_W    = 64;
  localparam int GW_W     = 4;
  localparam int LH_W     = 8;
  localparam int TW_W     = 16;
  localparam int TH_W     = 20;

  // Default number of width-table entries
  localparam int GLYPH_COUNT_DEF = 256;

  // Item kinds
  localparam logic KIND_GLYPH = 1'b0;
  localparam logic KIND_TEXT  = 1'b1;

  // Byte codes
  localparam logic [CODE_W-1:0] ESC_BYTE   = 8'hA7;
  localparam logic [CODE_W-1:0] SPACE_BYTE = 8'h20;
  localparam logic [CODE_W-1:0] NL_BYTE    = 8'h0A;

  // Glyph widths with fixed meaning
  localparam logic [GW_W-1:0] SPACE_WIDTH = 4'd4;
  localparam logic [GW_W-1:0] EMPTY_WIDTH = 4'd1;

  // Saturation limits and register reset
  localparam logic [TW_W-1:0] WIDTH_MAX  = 16'hFFFF;
  localparam logic [TH_W-1:0] HEIGHT_MAX = 20'hFFFFF;
  localparam logic [LH_W-1:0] LINE_HEIGHT_RST = 8'd10;

  // Text item leaving the table stage towards the accumulator
  typedef struct packed {
    logic              valid;
    logic              is_text;
    logic [CODE_W-1:0] code;
    logic              in_range;
    logic              last;
  } item_t;

endpackage

// ===== src/ptm_in_if.sv =====
// Input channel interface: glyph and text byte transactions.
`timescale 1ns / 1ps

interface ptm_in_if;
  import ptm_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [CODE_W-1:0] code;
  logic [PIX_W-1:0] glyph_pixels;
  logic             last;

  modport source (output valid, kind, code, glyph_pixels, last, input ready);
  modport sink   (input valid, kind, code, glyph_pixels, last, output ready);
endinterface

// ===== src/ptm_out_if.sv =====
// Result channel interface: measured text extents.
`timescale 1ns / 1ps

interface ptm_out_if;
  import ptm_pkg::*;

  logic            valid;
  logic            ready;
  logic [TW_W-1:0] text_width;
  logic [TH_W-1:0] text_height;
  logic            saturated;

  modport source (output valid, text_width, text_height, saturated, input ready);
  modport sink   (input valid, text_width, text_height, saturated, output ready);
endinterface

// ===== src/proportional_text_measure.sv =====
// Top level of the proportional text measure block.
`timescale 1ns / 1ps

// Measures the pixel extent of text set in a proportional 8x8 font. Glyph
// transactions load a per-code width (rightmost occupied column plus two, one for
// an empty glyph, four for the space); text transactions stream a string one byte
// per transaction and the final byte yields one result with the widest line, the
// height from lines started after newlines and a saturation flag. One transaction
// is taken every clock unless the input stalls; after its final byte is accepted,
// a result passes the input register, the registered read port of the width
// table and the result register. The input stalls only when a final byte
// reaches the accumulator while the previous result has not been taken. A glyph
// may be followed at once by text that uses it. Table entries hold no value until
// their glyph has been loaded.
module proportional_text_measure #(
  parameter int GLYPH_COUNT = ptm_pkg::GLYPH_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ptm_in_if.sink                    in_chan,
  ptm_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [ptm_pkg::LH_W-1:0]  cfg_wdata
);
  import ptm_pkg::*;

  logic            adv;
  item_t           item;
  logic [GW_W-1:0] width;
  logic [LH_W-1:0] line_height_r;

  // Line height register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_height_r <= LINE_HEIGHT_RST;
    end else if (cfg_we) begin
      line_height_r <= cfg_wdata;
    end
  end

  assign in_chan.ready = adv;

  // Input register and width table
  ptm_glyph_table #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_take   (in_chan.valid),
    .in_kind   (in_chan.kind),
    .in_code   (in_chan.code),
    .in_pixels (in_chan.glyph_pixels),
    .in_last   (in_chan.last),
    .item_o    (item),
    .width_o   (width)
  );

  // Accumulator and result register
  ptm_text_accum u_accum (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_i          (item),
    .width_i         (width),
    .line_height     (line_height_r),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_text_width  (out_chan.text_width),
    .out_text_height (out_chan.text_height),
    .out_saturated   (out_chan.saturated),
    .adv             (adv)
  );

endmodule

// ===== src/ptm_glyph_table.sv =====
// Input register, glyph width extraction and the glyph width table memory.
`timescale 1ns / 1ps

module ptm_glyph_table #(
  parameter int GLYPH_COUNT = ptm_pkg::GLYPH_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_take,
  input  logic                          in_kind,
  input  logic [ptm_pkg::CODE_W-1:0]    in_code,
  input  logic [ptm_pkg::PIX_W-1:0]     in_pixels,
  input  logic                          in_last,
  output ptm_pkg::item_t                item_o,
  output logic [ptm_pkg::GW_W-1:0]      width_o
);
  import ptm_pkg::*;

  localparam int IDX_W = $clog2(GLYPH_COUNT);
  localparam logic [CODE_W:0] CODE_LIM = (CODE_W+1)'(GLYPH_COUNT);

  // Input register
  logic              s1_valid_r;
  logic              s1_kind_r;
  logic [CODE_W-1:0] s1_code_r;
  logic [PIX_W-1:0]  s1_pixels_r;
  logic              s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r   <= in_kind;
      s1_code_r   <= in_code;
      s1_pixels_r <= in_pixels;
      s1_last_r   <= in_last;
    end
  end

  // Rightmost occupied column plus two; empty glyphs and the space get fixed widths
  logic [7:0]      col_occ;
  logic [GW_W-1:0] glyph_w;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      col_occ[c] = 1'b0;
      for (int r = 0; r < 8; r++) begin
        col_occ[c] = col_occ[c] | s1_pixels_r[r*8 + c];
      end
    end
    glyph_w = EMPTY_WIDTH;
    for (int c = 0; c < 8; c++) begin
      if (col_occ[c]) begin
        glyph_w = GW_W'(c + 2);
      end
    end
    if (s1_code_r == SPACE_BYTE) begin
      glyph_w = SPACE_WIDTH;
    end
  end

  logic             s1_in_range;
  logic [IDX_W-1:0] s1_idx;

  assign s1_in_range = ({1'b0, s1_code_r} < CODE_LIM);
  assign s1_idx      = s1_code_r[IDX_W-1:0];

  // Width table: one write and one registered read per cycle while the pipeline advances
  logic [GW_W-1:0] width_mem [GLYPH_COUNT];
  logic [GW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r && (s1_kind_r == KIND_GLYPH) && s1_in_range) begin
      width_mem[s1_idx] <= glyph_w;
    end
    if (adv) begin
      rd_data_r <= width_mem[s1_idx];
    end
  end

  // Text item register alongside the read data
  logic              s2_valid_r;
  logic              s2_is_text_r;
  logic [CODE_W-1:0] s2_code_r;
  logic              s2_in_range_r;
  logic              s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_is_text_r  <= (s1_kind_r == KIND_TEXT);
      s2_code_r     <= s1_code_r;
      s2_in_range_r <= s1_in_range;
      s2_last_r     <= s1_last_r;
    end
  end

  assign item_o  = '{valid: s2_valid_r, is_text: s2_is_text_r, code: s2_code_r,
                     in_range: s2_in_range_r, last: s2_last_r};
  assign width_o = rd_data_r;

endmodule

// ===== src/ptm_text_accum.sv =====
// Line width and height accumulation with the result register.
`timescale 1ns / 1ps

module ptm_text_accum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ptm_pkg::item_t             item_i,
  input  logic [ptm_pkg::GW_W-1:0]   width_i,
  input  logic [ptm_pkg::LH_W-1:0]   line_height,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [ptm_pkg::TW_W-1:0]   out_text_width,
  output logic [ptm_pkg::TH_W-1:0]   out_text_height,
  output logic                       out_saturated,
  output logic                       adv
);
  import ptm_pkg::*;

  logic [TW_W-1:0] line_width_r,  line_width_nxt;
  logic [TW_W-1:0] widest_line_r, widest_line_nxt;
  logic [TH_W-1:0] height_sum_r,  height_sum_nxt;
  logic            skip_next_r,   skip_next_nxt;
  logic            after_nl_r,    after_nl_nxt;
  logic            overflow_r,    overflow_nxt;

  logic            out_valid_r;
  logic [TW_W-1:0] out_width_r;
  logic [TH_W-1:0] out_height_r;
  logic            out_sat_r;

  logic is_text;
  logic emit;

  assign is_text = item_i.valid && item_i.is_text;
  assign emit    = is_text && item_i.last;

  // The pipeline holds only when a final transaction meets a full result register that is not being taken
  assign adv = !(emit && out_valid_r && !out_ready);

  // Next text state for the byte in the accumulate stage
  logic [TH_W:0]   h_sum;
  logic [TW_W:0]   w_sum;
  logic [GW_W-1:0] w_add;
  logic [TW_W-1:0] fin_width;

  always_comb begin
    line_width_nxt  = line_width_r;
    widest_line_nxt = widest_line_r;
    height_sum_nxt  = height_sum_r;
    skip_next_nxt   = skip_next_r;
    after_nl_nxt    = after_nl_r;
    overflow_nxt    = overflow_r;
    h_sum = {1'b0, height_sum_r} + (TH_W+1)'(line_height);
    w_add = item_i.in_range ? width_i : '0;
    w_sum = {1'b0, line_width_r} + (TW_W+1)'(w_add);

    // Height sees every byte, escapes included
    if (item_i.code == NL_BYTE) begin
      after_nl_nxt = 1'b1;
    end else begin
      if (after_nl_r) begin
        if (h_sum >= {1'b0, HEIGHT_MAX}) begin
          height_sum_nxt = HEIGHT_MAX;
          overflow_nxt   = 1'b1;
        end else begin
          height_sum_nxt = h_sum[TH_W-1:0];
        end
      end
      after_nl_nxt = 1'b0;
    end

    // Width skips the escape byte and the byte after it
    if (skip_next_r) begin
      skip_next_nxt = 1'b0;
    end else if (item_i.code == ESC_BYTE) begin
      skip_next_nxt = 1'b1;
    end else if (item_i.code == NL_BYTE) begin
      if (line_width_r > widest_line_r) begin
        widest_line_nxt = line_width_r;
      end
      line_width_nxt = '0;
    end else begin
      if (w_sum >= {1'b0, WIDTH_MAX}) begin
        line_width_nxt = WIDTH_MAX;
        overflow_nxt   = 1'b1;
      end else begin
        line_width_nxt = w_sum[TW_W-1:0];
      end
    end

    fin_width = (widest_line_nxt > line_width_nxt) ? widest_line_nxt : line_width_nxt;
  end

  // Text state: updated per byte, cleared after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r  <= '0;
      widest_line_r <= '0;
      height_sum_r  <= '0;
      skip_next_r   <= 1'b0;
      after_nl_r    <= 1'b0;
      overflow_r    <= 1'b0;
    end else if (adv && is_text) begin
      if (item_i.last) begin
        line_width_r  <= '0;
        widest_line_r <= '0;
        height_sum_r  <= '0;
        skip_next_r   <= 1'b0;
        after_nl_r    <= 1'b0;
        overflow_r    <= 1'b0;
      end else begin
        line_width_r  <= line_width_nxt;
        widest_line_r <= widest_line_nxt;
        height_sum_r  <= height_sum_nxt;
        skip_next_r   <= skip_next_nxt;
        after_nl_r    <= after_nl_nxt;
        overflow_r    <= overflow_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_width_r  <= fin_width;
      out_height_r <= height_sum_nxt;
      out_sat_r    <= overflow_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_text_width  = out_width_r;
  assign out_text_height = out_height_r;
  assign out_saturated   = out_sat_r;

  // A final transaction always leaves the text state cleared
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && emit) |=> (line_width_r == '0 && widest_line_r == '0 && height_sum_r == '0
                       && !overflow_r && !skip_next_r))
    else $error("text state not cleared after final transaction");

  // A saturated result carries at least one sum at its limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |-> (out_width_r == WIDTH_MAX || out_height_r == HEIGHT_MAX))
    else $error("saturated flag without a sum at its limit");

  // While the pipeline holds, the text state does not move
  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(line_width_r) && $stable(height_sum_r) && $stable(widest_line_r)))
    else $error("text state changed during a stall");

  // A stall only happens with a result waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> (out_valid_r && emit))
    else $error("pipeline stalled without a waiting result");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the proportional text measure block.
`timescale 1ns / 1ps

module tb;
  import ptm_pkg::*;

  // Run limits and waits
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 400;

  // Character codes used by the directed strings
  localparam logic [CODE_W-1:0] CH_NUL = 8'h00;
  localparam logic [CODE_W-1:0] CH_ONE = 8'h01;
  localparam logic [CODE_W-1:0] CH_A   = 8'h41;
  localparam logic [CODE_W-1:0] CH_B   = 8'h42;
  localparam logic [CODE_W-1:0] CH_TOP = 8'hFF;
  localparam logic [CODE_W-1:0] CH_UNL = 8'h99;

  // One input transaction
  typedef struct {
    logic              kind;
    logic [CODE_W-1:0] code;
    logic [PIX_W-1:0]  pixels;
    logic              last;
  } feed_t;

  // One measured extent
  typedef struct packed {
    logic [TW_W-1:0] width;
    logic [TH_W-1:0] height;
    logic            sat;
  } extent_t;

  // Directed stimulus row, with an optional hand-written expectation
  typedef struct {
    feed_t   f;
    bit      typed;
    extent_t ext;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [LH_W-1:0] cfg_wdata;

  ptm_in_if  in_if ();
  ptm_out_if out_if ();

  proportional_text_measure dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Predicted block state
  logic [GW_W-1:0]   width_of [256];
  bit                glyph_known [256];
  logic [CODE_W-1:0] known_codes [$];
  int unsigned       line_w;
  int unsigned       widest_w;
  int unsigned       height_acc;
  bit                skip_pending;
  bit                after_nl;
  bit                sat_seen;
  logic [LH_W-1:0]   line_height_cur;

  extent_t extents_due [$];
  row_t    directed_rows [$];

  int errors;
  int glyphs_sent;
  int strings_sent;
  int results_checked;
  int cycles;
  bit pace_burst;
  bit long_hold_req;

  // Clock generation
  initial begin
    forever #10 clk = ~clk;
  end

  // Width of a glyph: rightmost occupied column plus two, one when empty, four for the space.
  function automatic logic [GW_W-1:0] glyph_width_of(input logic [CODE_W-1:0] code,
                                                      input logic [PIX_W-1:0] pix);
    if (code == SPACE_BYTE) return SPACE_WIDTH;
    for (int col = 7; col >= 0; col--) begin
      for (int row = 0; row < 8; row++) begin
        if (pix[row*8 + col]) return GW_W'(col + 2);
      end
    end
    return EMPTY_WIDTH;
  endfunction

  // Clears the per-string measurement state.
  function automatic void clear_string();
    line_w       = 0;
    widest_w     = 0;
    height_acc   = 0;
    skip_pending = 1'b0;
    after_nl     = 1'b0;
    sat_seen     = 1'b0;
  endfunction

  // Advances the predicted state by one transaction; returns 1 with the extent on a final byte.
  function automatic bit step_measure(input feed_t f, output extent_t ext);
    int unsigned sum;
    ext = '0;
    if (f.kind == KIND_GLYPH) begin
      width_of[f.code] = glyph_width_of(f.code, f.pixels);
      if (!glyph_known[f.code]) begin
        glyph_known[f.code] = 1'b1;
        known_codes.insert(known_codes.size(), f.code);
      end
      return 1'b0;
    end
    // Height sees every byte, escaped ones included.
    if (f.code == NL_BYTE) begin
      after_nl = 1'b1;
    end else begin
      if (after_nl) begin
        sum = height_acc + 32'(line_height_cur);
        if (sum >= 32'(HEIGHT_MAX)) begin
          sum = 32'(HEIGHT_MAX);
          sat_seen = 1'b1;
        end
        height_acc = sum;
      end
      after_nl = 1'b0;
    end
    // Width: the escape byte and the byte after it add nothing.
    if (skip_pending) begin
      skip_pending = 1'b0;
    end else if (f.code == ESC_BYTE) begin
      skip_pending = 1'b1;
    end else if (f.code == NL_BYTE) begin
      if (line_w > widest_w) widest_w = line_w;
      line_w = 0;
    end else begin
      sum = line_w + 32'(width_of[f.code]);
      if (sum >= 32'(WIDTH_MAX)) begin
        sum = 32'(WIDTH_MAX);
        sat_seen = 1'b1;
      end
      line_w = sum;
    end
    if (!f.last) return 1'b0;
    ext.width  = TW_W'((widest_w > line_w) ? widest_w : line_w);
    ext.height = TH_W'(height_acc);
    ext.sat    = sat_seen;
    clear_string();
    return 1'b1;
  endfunction

  // True when a text byte would look up the width table in the current state.
  function automatic bit reads_table(input logic [CODE_W-1:0] code);
    return !skip_pending && code != ESC_BYTE && code != NL_BYTE;
  endfunction

  function automatic logic [CODE_W-1:0] pick_known();
    return known_codes[$urandom_range(0, known_codes.size() - 1)];
  endfunction

  // Offers one transaction after a drawn gap and records its expected extent on acceptance.
  task automatic offer_feed(input feed_t f, input bit typed, input extent_t typed_ext);
    int gap;
    extent_t ext;
    gap = pace_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= f.kind;
    in_if.code         <= f.code;
    in_if.glyph_pixels <= f.pixels;
    in_if.last         <= f.last;
    do @(posedge clk); while (!in_if.ready);
    if (f.kind == KIND_GLYPH) glyphs_sent++;
    else if (f.last) strings_sent++;
    if (step_measure(f, ext)) extents_due.insert(extents_due.size(), typed ? typed_ext : ext);
  endtask

  task automatic send(input logic kind, input logic [CODE_W-1:0] code,
                      input logic [PIX_W-1:0] pix, input logic last);
    feed_t f;
    f.kind   = kind;
    f.code   = code;
    f.pixels = pix;
    f.last   = last;
    offer_feed(f, 1'b0, '0);
  endtask

  task automatic add_row(input logic kind, input logic [CODE_W-1:0] code,
                         input logic [PIX_W-1:0] pix, input logic last, input bit typed,
                         input logic [TW_W-1:0] w, input logic [TH_W-1:0] h,
                         input logic sat);
    row_t r;
    r.f.kind     = kind;
    r.f.code     = code;
    r.f.pixels   = pix;
    r.f.last     = last;
    r.typed      = typed;
    r.ext.width  = w;
    r.ext.height = h;
    r.ext.sat    = sat;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // Lowers valid, waits for every outstanding result and lets the pipeline drain.
  task automatic settle_idle();
    in_if.valid <= 1'b0;
    while (extents_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_line_height(input logic [LH_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    line_height_cur = v;
  endtask

  // Random glyph loads and strings of random content drawn from loaded glyphs.
  task automatic random_phase(input int n_items);
    int sent;
    int len;
    int r;
    int col;
    logic [CODE_W-1:0] c;
    logic [PIX_W-1:0] pix;
    sent = 0;
    while (sent < n_items) begin
      pace_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 15) begin
        // Glyph load: empty, fully random or limited to the leftmost columns.
        r   = $urandom_range(0, 2);
        col = $urandom_range(0, 7);
        pix = {$urandom, $urandom};
        if (r == 0) pix = '0;
        else if (r == 2) pix = pix & {8{8'((16'd1 << (col + 1)) - 1)}};
        send(KIND_GLYPH, CODE_W'($urandom_range(0, 255)), pix, 1'($urandom));
        sent++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          if (r < 15) c = NL_BYTE;
          else if (r < 23) c = ESC_BYTE;
          else if (r < 30) c = CODE_W'($urandom_range(0, 255));
          else c = pick_known();
          // Never look up an entry whose glyph has not been loaded.
          if (reads_table(c) && !glyph_known[c]) c = pick_known();
          send(KIND_TEXT, c, {$urandom, $urandom}, i == len - 1);
          sent++;
        end
      end
    end
  endtask

  // Result side: random stalls, one long hold-off on request, and checking.
  initial begin : result_sink
    int gap;
    bit recv_burst;
    extent_t due;
    recv_burst = 1'b0;
    out_if.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = recv_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      results_checked++;
      if (extents_due.size() == 0) begin
        $error("unexpected result: text_width %0d text_height %0d saturated %0d",
               out_if.text_width, out_if.text_height, out_if.saturated);
        errors++;
      end else begin
        due = extents_due.pop_front();
        if (out_if.text_width !== due.width) begin
          $error("text_width: expected %0d, got %0d", due.width, out_if.text_width);
          errors++;
        end
        if (out_if.text_height !== due.height) begin
          $error("text_height: expected %0d, got %0d", due.height, out_if.text_height);
          errors++;
        end
        if (out_if.saturated !== due.sat) begin
          $error("saturated: expected %0d, got %0d", due.sat, out_if.saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus sequence.
  initial begin : stimulus
    in_if.valid        <= 1'b0;
    in_if.kind         <= KIND_GLYPH;
    in_if.code         <= '0;
    in_if.glyph_pixels <= '0;
    in_if.last         <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    errors          = 0;
    glyphs_sent     = 0;
    strings_sent    = 0;
    results_checked = 0;
    long_hold_req   = 1'b0;
    pace_burst      = 1'b0;
    line_height_cur = LINE_HEIGHT_RST;
    foreach (width_of[i]) begin
      width_of[i]    = '0;
      glyph_known[i] = 1'b0;
    end
    clear_string();

    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: glyph width extremes, then strings exercising each text rule.
    add_row(KIND_GLYPH, CH_A, '1, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(KIND_GLYPH, CH_ONE, 64'h1, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(KIND_GLYPH, CH_NUL, '0, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(KIND_GLYPH, SPACE_BYTE, '1, 1'b1, 1'b0, '0, '0, 1'b0);
    add_row(KIND_GLYPH, CH_TOP, 64'h8000_0000_0000_0000, 1'b0, 1'b0, '0, '0, 1'b0);
    // A glyph used by the very next text byte.
    add_row(KIND_GLYPH, CH_B, 64'h0000_0000_0010_0000, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(KIND_TEXT, CH_B, '0, 1'b1, 1'b1, 16'd6, 20'd0, 1'b0);
    add_row(KIND_TEXT, CH_A, '0, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(KIND_TEXT, SPACE_BYTE, '0, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(KIND_TEXT, CH_NUL, '0, 1'b1, 1'b1, 16'd14, 20'd0, 1'b0);
    add_row(KIND_TEXT, NL_BYTE, '0, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(KIND_TEXT, CH_TOP, '1, 1'b1, 1'b1, 16'd9, 20'd10, 1'b0);
    // An escaped newline adds no width but still starts a line for height.
    add_row(KIND_TEXT, ESC_BYTE, '0, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(KIND_TEXT, NL_BYTE, '0, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(KIND_TEXT, CH_A, '0, 1'b1, 1'b1, 16'd9, 20'd10, 1'b0);
    // An escape as the final byte must not leak into the next string.
    add_row(KIND_TEXT, CH_A, '0, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(KIND_TEXT, ESC_BYTE, '0, 1'b1, 1'b1, 16'd9, 20'd0, 1'b0);
    add_row(KIND_TEXT, CH_ONE, '0, 1'b1, 1'b1, 16'd2, 20'd0, 1'b0);
    // The escaped byte may be a code whose glyph was never loaded.
    add_row(KIND_TEXT, ESC_BYTE, '0, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(KIND_TEXT, CH_UNL, '0, 1'b1, 1'b1, 16'd0, 20'd0, 1'b0);
    // Back-to-back newlines count one line; a trailing newline counts none.
    add_row(KIND_TEXT, CH_A, '0, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(KIND_TEXT, NL_BYTE, '0, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(KIND_TEXT, NL_BYTE, '0, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(KIND_TEXT, CH_ONE, '0, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(KIND_TEXT, NL_BYTE, '0, 1'b1, 1'b1, 16'd9, 20'd10, 1'b0);
    foreach (directed_rows[i]) begin
      pace_burst = ($urandom_range(0, 1) == 0);
      offer_feed(directed_rows[i].f, directed_rows[i].typed, directed_rows[i].ext);
    end

    // Random phases at the line height extremes and at a random setting.
    settle_idle();
    write_line_height(8'd0);
    random_phase(180);
    settle_idle();
    write_line_height(8'd255);
    random_phase(180);
    settle_idle();
    write_line_height(LH_W'($urandom_range(2, 254)));
    long_hold_req = 1'b1;
    random_phase(220);

    settle_idle();
    write_line_height(8'd1);
    random_phase(40);
    settle_idle();

    $display("Covered %0d glyph loads and %0d strings, %0d results checked,", glyphs_sent,
             strings_sent, results_checked);
    $display("line heights 0, 1, 10, 255 and one random, with a long result hold-off.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ptm_pkg.sv
src/ptm_in_if.sv
src/ptm_out_if.sv
src/ptm_glyph_table.sv
src/ptm_text_accum.sv
src/proportional_text_measure.sv
tb/tb.sv
